@@ hw/rtl/qrs_pkg.sv @@
// Shared constants, state encoding, coefficient table and helpers for the QRS beat detector.
package qrs_pkg;

    // Structure
    localparam int WINDOW_LEN = 37;
    localparam int SECTIONS   = 3;
    localparam int POS_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    // Datapath widths
    localparam int SIG_W  = 48;   // filter values, Q16 signed
    localparam int MB_W   = 29;   // serial multiplier operand
    localparam int MHI_W  = 50;   // multiplier upper accumulator
    localparam int SQ_W   = 40;   // square and window entries
    localparam int TOT_W  = 48;   // window total
    localparam int THR_W  = 40;   // level and threshold, Q16 unsigned
    localparam int DIV_W  = 48;   // divider dividend / quotient
    localparam int DEN_W  = 32;   // divider divisor
    localparam int RATE_W = 24;   // smoothed rate, Q16

    localparam logic [4:0] MUL_LAST = 5'(MB_W - 1);
    localparam logic [5:0] DIV_LAST = 6'(DIV_W - 1);

    localparam logic [SQ_W-1:0]   SQ_MAX   = {SQ_W{1'b1}};
    localparam logic [39:0]       RATE_NUM = 40'd60000;
    localparam logic [DIV_W-1:0]  INST_NUM = 48'd3932160000;   // 60000 << 16
    localparam logic [DEN_W-1:0]  WIN_DEN  = 32'(WINDOW_LEN);
    localparam logic [DEN_W-1:0]  DECAY_DEN  = 32'd2000;
    localparam logic [DEN_W-1:0]  SMOOTH_DEN = 32'd10;

    // Register reset values
    localparam logic [9:0]  REFR_RST  = 10'd350;
    localparam logic [23:0] FLOOR_RST = 24'd2000;
    localparam logic [7:0]  RLOW_RST  = 8'd30;
    localparam logic [7:0]  RHIGH_RST = 8'd240;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_REFRACTORY = 2'd0,
        CFG_FLOOR      = 2'd1,
        CFG_RATE_LOW   = 2'd2,
        CFG_RATE_HIGH  = 2'd3
    } cfg_idx_t;

    // Coefficient positions within a section
    localparam int K_B0 = 0;
    localparam int K_B1 = 1;
    localparam int K_B2 = 2;
    localparam int K_A1 = 3;
    localparam int K_A2 = 4;

    // b0, b1, b2, a1, a2 with 24 fractional bits; last row passes through
    localparam logic signed [25:0] COEF_TAB [0:3][0:4] = '{
        '{ 26'sd26290, 26'sd52580, 26'sd26290, -26'sd29084360, 26'sd13013743 },
        '{ 26'sd16777216, 26'sd0, -26'sd16777216, -26'sd28816562, 26'sd13990123 },
        '{ 26'sd16777216, -26'sd33554432, 26'sd16777216, -26'sd32162349, 26'sd15669378 },
        '{ 26'sd16777216, 26'sd0, 26'sd0, 26'sd0, 26'sd0 }
    };

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEC_B0,
        ST_SEC_Y,
        ST_SEC_B1,
        ST_SEC_A1,
        ST_SEC_B2,
        ST_SEC_A2,
        ST_DIFF,
        ST_SQ,
        ST_WIN,
        ST_LVL,
        ST_DECAY,
        ST_BEAT,
        ST_RATE_LO,
        ST_RATE_HI,
        ST_INST,
        ST_SMOOTH,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // Coefficient sign-extended to the multiplier operand width
    function automatic logic [MB_W-1:0] coef(input logic [1:0] sec, input int k);
        logic signed [25:0] c;
        c = COEF_TAB[sec][k];
        return {{(MB_W-26){c[25]}}, c};
    endfunction

    // Saturate to 48-bit two's complement
    function automatic logic signed [SIG_W-1:0] sat48(input logic signed [55:0] v);
        logic signed [SIG_W-1:0] r;
        if ((&v[55:SIG_W-1]) || !(|v[55:SIG_W-1]))
            r = v[SIG_W-1:0];
        else if (v[55])
            r = {1'b1, {(SIG_W-1){1'b0}}};
        else
            r = {1'b0, {(SIG_W-1){1'b1}}};
        return r;
    endfunction

endpackage

@@ hw/rtl/qrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module qrs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 37
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/qrs_beat_detector.sv @@
// QRS beat detector: bandpass cascade, energy window, adaptive threshold and rate smoothing.
// One sample in gives one result out. Each sample runs through a sequencer built on a shared
// bit-serial multiplier (15 products for three filter sections plus one for the square,
// skipped when the difference is too large to square) and a shared restoring divider (one
// quotient for the window average, then, outside the refractory period, one for threshold
// decay or up to two for the rate), so a sample holds the input until the sequencer is back
// in idle, including any wait for the output register. The next sample is taken as soon as the
// sequencer is back in idle, even while the previous result still waits in the output register.
// The 37-entry energy window sits in a RAM; a valid mask makes entries count as zero until first written.
module qrs_beat_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] sample,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        beat,
    output logic        rate_updated,
    output logic [7:0]  rate_bpm,
    output logic [24:0] level
);

    qrs_pkg::state_t state_reg, state_next, ret_reg;

    // Configuration
    logic [9:0]  refr_reg;
    logic [23:0] floor_reg;
    logic [7:0]  rlow_reg;
    logic [7:0]  rhigh_reg;

    // Filter state
    logic signed [qrs_pkg::SIG_W-1:0] sa_reg [qrs_pkg::SECTIONS];
    logic signed [qrs_pkg::SIG_W-1:0] sb_reg [qrs_pkg::SECTIONS];
    logic signed [qrs_pkg::SIG_W-1:0] x_reg, y_reg, prev_reg;
    logic signed [54:0]               t1_reg;
    logic [qrs_pkg::SEC_W-1:0]        sec_reg;

    // Window and detection state
    logic [qrs_pkg::WINDOW_LEN-1:0] vld_reg;
    logic [qrs_pkg::POS_W-1:0]      pos_reg;
    logic [qrs_pkg::TOT_W-1:0]      total_reg;
    logic [qrs_pkg::SQ_W-1:0]       sq_reg;
    logic [qrs_pkg::THR_W-1:0]      lvl_reg, thr_reg;
    logic [31:0]                    now_reg, last_reg, delta_reg;
    logic [qrs_pkg::RATE_W-1:0]     sm_reg;
    logic                           had_reg, rvalid_reg, lo_ok_reg;
    logic                           beat_reg, upd_reg;

    // Serial multiplier
    logic signed [qrs_pkg::SIG_W-1:0] mul_a_reg;
    logic [qrs_pkg::MB_W-1:0]         mul_b_reg, mul_lo_reg;
    logic signed [qrs_pkg::MHI_W-1:0] mul_hi_reg;
    logic [4:0]                       mul_cnt_reg;

    // Serial divider
    logic [qrs_pkg::DIV_W-1:0] div_q_reg;
    logic [qrs_pkg::DEN_W-1:0] div_r_reg, div_d_reg;
    logic [5:0]                div_cnt_reg;

    // Output register
    logic        out_valid_reg, out_beat_reg, out_upd_reg;
    logic [7:0]  out_rate_reg;
    logic [24:0] out_level_reg;

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;

    // Multiplier step: add operand (negated on the sign bit), shift right
    logic signed [qrs_pkg::MHI_W-1:0] mul_aext, mul_add, mul_sum;
    always_comb
    begin
        mul_aext = qrs_pkg::MHI_W'(mul_a_reg);
        if (!mul_b_reg[0])
            mul_add = '0;
        else if (mul_cnt_reg == qrs_pkg::MUL_LAST)
            mul_add = -mul_aext;
        else
            mul_add = mul_aext;
        mul_sum = mul_hi_reg + mul_add;
    end

    // Product of a signal and a coefficient, floor divided by 2^24
    logic signed [54:0] p_coef;
    assign p_coef = $signed({mul_hi_reg, mul_lo_reg[qrs_pkg::MB_W-1:24]});

    // Divider step
    logic [qrs_pkg::DEN_W:0] div_r2, div_diff;
    logic                    div_ge;
    always_comb
    begin
        div_r2   = {div_r_reg, div_q_reg[qrs_pkg::DIV_W-1]};
        div_diff = div_r2 - {1'b0, div_d_reg};
        div_ge   = (div_r2 >= {1'b0, div_d_reg});
    end

    // Filter arithmetic for the current section
    logic signed [qrs_pkg::SIG_W-1:0] sec_y, sec_a, sec_b;
    always_comb
    begin
        sec_y = qrs_pkg::sat48(56'(p_coef) + 56'(sa_reg[sec_reg]));
        sec_a = qrs_pkg::sat48(56'(t1_reg) - 56'(p_coef) + 56'(sb_reg[sec_reg]));
        sec_b = qrs_pkg::sat48(56'(t1_reg) - 56'(p_coef));
    end

    // First difference and magnitude
    logic signed [49:0] diff;
    logic [49:0]        mag;
    always_comb
    begin
        diff = 50'(x_reg) - 50'(prev_reg);
        mag  = diff[49] ? 50'(-diff) : 50'(diff);
    end

    // Window update
    logic [qrs_pkg::SQ_W-1:0]  win_rd, win_old;
    logic [qrs_pkg::TOT_W-1:0] total_next;
    logic [qrs_pkg::POS_W-1:0] pos_inc;
    always_comb
    begin
        win_old    = vld_reg[pos_reg] ? win_rd : '0;
        total_next = total_reg - qrs_pkg::TOT_W'(win_old) + qrs_pkg::TOT_W'(sq_reg);
        pos_inc    = (pos_reg == qrs_pkg::POS_W'(qrs_pkg::WINDOW_LEN - 1)) ? '0
                   : pos_reg + 1'b1;
    end

    qrs_ram #(
        .WIDTH (qrs_pkg::SQ_W),
        .DEPTH (qrs_pkg::WINDOW_LEN)
    ) u_win_ram (
        .clk   (clk),
        .we    (state_reg == qrs_pkg::ST_WIN),
        .waddr (pos_reg),
        .wdata (sq_reg),
        .raddr (pos_reg),
        .rdata (win_rd)
    );

    // Detection arithmetic
    logic [qrs_pkg::THR_W-1:0] lvl_q, thr_floor, thr_dec;
    logic [31:0]               since;
    logic                      refr_ok;
    logic [39:0]               rate_prod;
    always_comb
    begin
        lvl_q     = div_q_reg[qrs_pkg::THR_W-1:0];
        thr_floor = {floor_reg, 16'd0};
        thr_dec   = thr_reg - div_q_reg[qrs_pkg::THR_W-1:0];
        since     = now_reg - last_reg;
        refr_ok   = (since >= {22'd0, refr_reg});
        rate_prod = (state_reg == qrs_pkg::ST_RATE_LO)
                  ? 40'(rlow_reg) * 40'(delta_reg) : 40'(rhigh_reg) * 40'(delta_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qrs_pkg::ST_IDLE:
            begin
                if (in_acc)
                    state_next = qrs_pkg::ST_SEC_B0;
            end
            qrs_pkg::ST_SEC_B0, qrs_pkg::ST_SEC_Y, qrs_pkg::ST_SEC_B1,
            qrs_pkg::ST_SEC_A1, qrs_pkg::ST_SEC_B2:
            begin
                state_next = qrs_pkg::ST_MUL;
            end
            qrs_pkg::ST_SEC_A2:
            begin
                if (sec_reg == qrs_pkg::SEC_W'(qrs_pkg::SECTIONS - 1))
                    state_next = qrs_pkg::ST_DIFF;
                else
                    state_next = qrs_pkg::ST_SEC_B0;
            end
            qrs_pkg::ST_DIFF:
            begin
                if (|mag[49:28])
                    state_next = qrs_pkg::ST_WIN;
                else
                    state_next = qrs_pkg::ST_MUL;
            end
            qrs_pkg::ST_SQ:
            begin
                state_next = qrs_pkg::ST_WIN;
            end
            qrs_pkg::ST_WIN:
            begin
                state_next = qrs_pkg::ST_DIV;
            end
            qrs_pkg::ST_LVL:
            begin
                priority if (!refr_ok)
                    state_next = qrs_pkg::ST_OUT;
                else if (lvl_q > thr_reg)
                    state_next = qrs_pkg::ST_BEAT;
                else
                    state_next = qrs_pkg::ST_DIV;
            end
            qrs_pkg::ST_DECAY:
            begin
                state_next = qrs_pkg::ST_OUT;
            end
            qrs_pkg::ST_BEAT:
            begin
                state_next = had_reg ? qrs_pkg::ST_RATE_LO : qrs_pkg::ST_OUT;
            end
            qrs_pkg::ST_RATE_LO:
            begin
                state_next = qrs_pkg::ST_RATE_HI;
            end
            qrs_pkg::ST_RATE_HI:
            begin
                if (lo_ok_reg && (qrs_pkg::RATE_NUM < rate_prod))
                    state_next = qrs_pkg::ST_DIV;
                else
                    state_next = qrs_pkg::ST_OUT;
            end
            qrs_pkg::ST_INST:
            begin
                state_next = rvalid_reg ? qrs_pkg::ST_DIV : qrs_pkg::ST_OUT;
            end
            qrs_pkg::ST_SMOOTH:
            begin
                state_next = qrs_pkg::ST_OUT;
            end
            qrs_pkg::ST_MUL:
            begin
                if (mul_cnt_reg == qrs_pkg::MUL_LAST)
                    state_next = ret_reg;
            end
            qrs_pkg::ST_DIV:
            begin
                if (div_cnt_reg == qrs_pkg::DIV_LAST)
                    state_next = ret_reg;
            end
            qrs_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = qrs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = qrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Port outputs
    assign in_stall     = (state_reg != qrs_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign beat         = out_beat_reg;
    assign rate_updated = out_upd_reg;
    assign rate_bpm     = out_rate_reg;
    assign level        = out_level_reg;

    // Datapath and sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qrs_pkg::ST_IDLE;
            ret_reg       <= qrs_pkg::ST_IDLE;
            refr_reg      <= qrs_pkg::REFR_RST;
            floor_reg     <= qrs_pkg::FLOOR_RST;
            rlow_reg      <= qrs_pkg::RLOW_RST;
            rhigh_reg     <= qrs_pkg::RHIGH_RST;
            for (int i = 0; i < qrs_pkg::SECTIONS; i++)
            begin
                sa_reg[i] <= '0;
                sb_reg[i] <= '0;
            end
            x_reg         <= '0;
            y_reg         <= '0;
            prev_reg      <= '0;
            t1_reg        <= '0;
            sec_reg       <= '0;
            vld_reg       <= '0;
            pos_reg       <= '0;
            total_reg     <= '0;
            sq_reg        <= '0;
            lvl_reg       <= '0;
            thr_reg       <= {qrs_pkg::FLOOR_RST, 16'd0};
            now_reg       <= '0;
            last_reg      <= '0;
            delta_reg     <= '0;
            sm_reg        <= '0;
            had_reg       <= 1'b0;
            rvalid_reg    <= 1'b0;
            lo_ok_reg     <= 1'b0;
            beat_reg      <= 1'b0;
            upd_reg       <= 1'b0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_lo_reg    <= '0;
            mul_hi_reg    <= '0;
            mul_cnt_reg   <= '0;
            div_q_reg     <= '0;
            div_r_reg     <= '0;
            div_d_reg     <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_beat_reg  <= 1'b0;
            out_upd_reg   <= 1'b0;
            out_rate_reg  <= '0;
            out_level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_we)
            begin
                unique case (qrs_pkg::cfg_idx_t'(cfg_index))
                    qrs_pkg::CFG_REFRACTORY: refr_reg  <= cfg_data[9:0];
                    qrs_pkg::CFG_FLOOR:      floor_reg <= cfg_data;
                    qrs_pkg::CFG_RATE_LOW:   rlow_reg  <= cfg_data[7:0];
                    qrs_pkg::CFG_RATE_HIGH:  rhigh_reg <= cfg_data[7:0];
                endcase
            end

            // Result taken; the output state reloads it itself
            if (out_acc && (state_reg != qrs_pkg::ST_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                qrs_pkg::ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        x_reg    <= qrs_pkg::SIG_W'({sample, 16'd0});
                        now_reg  <= now_ms;
                        sec_reg  <= '0;
                        beat_reg <= 1'b0;
                        upd_reg  <= 1'b0;
                    end
                end
                qrs_pkg::ST_SEC_B0:
                begin
                    mul_a_reg   <= x_reg;
                    mul_b_reg   <= qrs_pkg::coef(2'(sec_reg), qrs_pkg::K_B0);
                    mul_hi_reg  <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= qrs_pkg::ST_SEC_Y;
                end
                qrs_pkg::ST_SEC_Y:
                begin
                    y_reg       <= sec_y;
                    mul_a_reg   <= x_reg;
                    mul_b_reg   <= qrs_pkg::coef(2'(sec_reg), qrs_pkg::K_B1);
                    mul_hi_reg  <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= qrs_pkg::ST_SEC_B1;
                end
                qrs_pkg::ST_SEC_B1:
                begin
                    t1_reg      <= p_coef;
                    mul_a_reg   <= y_reg;
                    mul_b_reg   <= qrs_pkg::coef(2'(sec_reg), qrs_pkg::K_A1);
                    mul_hi_reg  <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= qrs_pkg::ST_SEC_A1;
                end
                qrs_pkg::ST_SEC_A1:
                begin
                    sa_reg[sec_reg] <= sec_a;
                    mul_a_reg       <= x_reg;
                    mul_b_reg       <= qrs_pkg::coef(2'(sec_reg), qrs_pkg::K_B2);
                    mul_hi_reg      <= '0;
                    mul_cnt_reg     <= '0;
                    ret_reg         <= qrs_pkg::ST_SEC_B2;
                end
                qrs_pkg::ST_SEC_B2:
                begin
                    t1_reg      <= p_coef;
                    mul_a_reg   <= y_reg;
                    mul_b_reg   <= qrs_pkg::coef(2'(sec_reg), qrs_pkg::K_A2);
                    mul_hi_reg  <= '0;
                    mul_cnt_reg <= '0;
                    ret_reg     <= qrs_pkg::ST_SEC_A2;
                end
                qrs_pkg::ST_SEC_A2:
                begin
                    sb_reg[sec_reg] <= sec_b;
                    x_reg           <= y_reg;
                    sec_reg         <= sec_reg + 1'b1;
                end
                qrs_pkg::ST_DIFF:
                begin
                    prev_reg <= x_reg;
                    if (|mag[49:28])
                    begin
                        sq_reg <= qrs_pkg::SQ_MAX;
                    end
                    else
                    begin
                        mul_a_reg   <= mag[qrs_pkg::SIG_W-1:0];
                        mul_b_reg   <= {1'b0, mag[27:0]};
                        mul_hi_reg  <= '0;
                        mul_cnt_reg <= '0;
                        ret_reg     <= qrs_pkg::ST_SQ;
                    end
                end
                qrs_pkg::ST_SQ:
                begin
                    sq_reg <= {mul_hi_reg[26:0], mul_lo_reg[qrs_pkg::MB_W-1:16]};
                end
                qrs_pkg::ST_WIN:
                begin
                    total_reg        <= total_next;
                    vld_reg[pos_reg] <= 1'b1;
                    pos_reg          <= pos_inc;
                    div_q_reg        <= total_next;
                    div_r_reg        <= '0;
                    div_d_reg        <= qrs_pkg::WIN_DEN;
                    div_cnt_reg      <= '0;
                    ret_reg          <= qrs_pkg::ST_LVL;
                end
                qrs_pkg::ST_LVL:
                begin
                    lvl_reg     <= lvl_q;
                    div_q_reg   <= qrs_pkg::DIV_W'(thr_reg);
                    div_r_reg   <= '0;
                    div_d_reg   <= qrs_pkg::DECAY_DEN;
                    div_cnt_reg <= '0;
                    ret_reg     <= qrs_pkg::ST_DECAY;
                end
                qrs_pkg::ST_DECAY:
                begin
                    thr_reg <= (thr_dec < thr_floor) ? thr_floor : thr_dec;
                end
                qrs_pkg::ST_BEAT:
                begin
                    thr_reg   <= thr_reg + ((lvl_reg - thr_reg) >> 3);
                    beat_reg  <= 1'b1;
                    delta_reg <= since;
                    last_reg  <= now_reg;
                    had_reg   <= 1'b1;
                end
                qrs_pkg::ST_RATE_LO:
                begin
                    lo_ok_reg <= (qrs_pkg::RATE_NUM > rate_prod);
                end
                qrs_pkg::ST_RATE_HI:
                begin
                    div_q_reg   <= qrs_pkg::INST_NUM;
                    div_r_reg   <= '0;
                    div_d_reg   <= delta_reg;
                    div_cnt_reg <= '0;
                    ret_reg     <= qrs_pkg::ST_INST;
                end
                qrs_pkg::ST_INST:
                begin
                    if (!rvalid_reg)
                    begin
                        sm_reg     <= div_q_reg[qrs_pkg::RATE_W-1:0];
                        rvalid_reg <= 1'b1;
                        upd_reg    <= 1'b1;
                    end
                    else
                    begin
                        div_q_reg   <= qrs_pkg::DIV_W'({sm_reg, 3'd0})
                                     + qrs_pkg::DIV_W'(sm_reg) + div_q_reg;
                        div_r_reg   <= '0;
                        div_d_reg   <= qrs_pkg::SMOOTH_DEN;
                        div_cnt_reg <= '0;
                        ret_reg     <= qrs_pkg::ST_SMOOTH;
                    end
                end
                qrs_pkg::ST_SMOOTH:
                begin
                    sm_reg  <= div_q_reg[qrs_pkg::RATE_W-1:0];
                    upd_reg <= 1'b1;
                end
                qrs_pkg::ST_MUL:
                begin
                    mul_hi_reg  <= mul_sum >>> 1;
                    mul_lo_reg  <= {mul_sum[0], mul_lo_reg[qrs_pkg::MB_W-1:1]};
                    mul_b_reg   <= mul_b_reg >> 1;
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                end
                qrs_pkg::ST_DIV:
                begin
                    div_r_reg   <= div_ge ? div_diff[qrs_pkg::DEN_W-1:0]
                                          : div_r2[qrs_pkg::DEN_W-1:0];
                    div_q_reg   <= {div_q_reg[qrs_pkg::DIV_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                qrs_pkg::ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_beat_reg  <= beat_reg;
                        out_upd_reg   <= upd_reg;
                        out_rate_reg  <= sm_reg[23:16];
                        out_level_reg <= {1'b0, lvl_reg[39:16]};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Window pointer never leaves the window
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= qrs_pkg::POS_W'(qrs_pkg::WINDOW_LEN - 1))
        else $error("window position out of range");

    // A rate update only comes with a beat
    a_upd_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_upd_reg || out_beat_reg))
        else $error("rate update without beat");

    // An accepted sample starts the filter sequence
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == qrs_pkg::ST_SEC_B0))
        else $error("sample accepted but sequencer did not start");

    // Leaving a multiply returns to the state that requested it
    a_mul_ret: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qrs_pkg::ST_MUL && mul_cnt_reg == qrs_pkg::MUL_LAST)
        |=> (state_reg == $past(ret_reg)))
        else $error("multiplier returned to wrong state");

endmodule
